// File: sv/l1ada_pkg.sv
// Shared types and constants for the L1 AdaGrad dual-averaging update block.
package l1ada_pkg;

  localparam int ELEM_COUNT = 1024;
  localparam int SLOT_W     = $clog2(ELEM_COUNT);

  localparam int IDX_W   = 10;
  localparam int GRAD_W  = 32;
  localparam int CNT_W   = 20;
  localparam int REG_W   = 31;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int SQ_W    = 64;
  localparam int SUM_W   = 48;
  localparam int THR_W   = REG_W + CNT_W;
  localparam int NUM_W   = REG_W + SUM_W;
  localparam int ROOT_W  = 32;
  localparam int HALF_W  = SUM_W / 2;

  localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = CFG_IDX_W'(1);

  localparam logic [REG_W-1:0] GAIN_RESET = REG_W'(65536);

  typedef struct packed {
    logic [IDX_W-1:0]         element_index;
    logic signed [GRAD_W-1:0] gradient_value;
    logic [CNT_W-1:0]         iteration_count;
    logic                     first_pass;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         result_index;
    logic signed [GRAD_W-1:0] coefficient_value;
    logic                     saturated;
  } out_item_t;

  // Per-item control that rides alongside the root and divide pipelines.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             pos;
    logic             nz;
    logic             sat;
  } coef_ctx_t;

  typedef struct packed {
    coef_ctx_t          c;
    logic [NUM_W-1:0]   num;
  } root_ctx_t;

endpackage

// File: sv/l1ada_isqrt.sv
// Pipelined floor square root of a 64-bit value, one result bit per stage.
module l1ada_isqrt import l1ada_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [SQ_W-1:0]   in_rad,
  input  root_ctx_t         in_ctx,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output root_ctx_t         out_ctx
);

  localparam int STEPS = SQ_W / 2;

  logic              vld [0:STEPS];
  logic [SQ_W-1:0]   rem [0:STEPS];
  logic [SQ_W-1:0]   res [0:STEPS];
  root_ctx_t         ctx [0:STEPS];

  assign vld[0] = in_vld;
  assign rem[0] = in_rad;
  assign res[0] = '0;
  assign ctx[0] = in_ctx;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] trial;
    assign trial = res[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctx[k+1] <= ctx[k];
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign out_vld  = vld[STEPS];
  assign out_root = res[STEPS][ROOT_W-1:0];
  assign out_ctx  = ctx[STEPS];

endmodule

// File: sv/l1ada_div.sv
// Pipelined restoring divider: 32 quotient bits plus an overflow flag.
module l1ada_div import l1ada_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [ROOT_W-1:0] in_den,
  input  coef_ctx_t         in_ctx,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_quo,
  output logic              out_ovf,
  output coef_ctx_t         out_ctx
);

  localparam int STEPS = ROOT_W;
  localparam int HI_W  = NUM_W - ROOT_W;

  logic              vld [0:STEPS];
  logic [ROOT_W-1:0] rem [0:STEPS];
  logic [ROOT_W-1:0] lo  [0:STEPS];
  logic [ROOT_W-1:0] quo [0:STEPS];
  logic [ROOT_W-1:0] den [0:STEPS];
  logic              ovf [0:STEPS];
  coef_ctx_t         ctx [0:STEPS];

  // The quotient needs more than 32 bits exactly when the high part is not below the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ovf[0] <= in_num[NUM_W-1:ROOT_W] >= HI_W'(in_den);
      rem[0] <= in_num[SQ_W-1:ROOT_W];
      lo[0]  <= in_num[ROOT_W-1:0];
      quo[0] <= '0;
      den[0] <= in_den;
      ctx[0] <= in_ctx;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [ROOT_W:0] trial;
    logic            ge;
    assign trial = {rem[k], lo[k][ROOT_W-1]};
    assign ge    = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= ge ? ROOT_W'(trial - {1'b0, den[k]}) : trial[ROOT_W-1:0];
        lo[k+1]  <= lo[k] << 1;
        quo[k+1] <= {quo[k][ROOT_W-2:0], ge};
        den[k+1] <= den[k];
        ovf[k+1] <= ovf[k];
        ctx[k+1] <= ctx[k];
      end
    end
  end

  assign out_vld = vld[STEPS];
  assign out_quo = quo[STEPS];
  assign out_ovf = ovf[STEPS];
  assign out_ctx = ctx[STEPS];

endmodule

// File: sv/l1_adagrad_dual_averaging_update.sv
// Top level of the L1 AdaGrad dual-averaging update: state memory, sums, root and divide.
// Throughput: one transaction per cycle each way, no gaps between items, unless out_stall or clearing holds it.
// Pipeline: from the accepting edge of the input transaction to out_valid, the path holds
//   six arithmetic stages, the 32-stage square root, the 33-stage divider and the output
//   register.
// Reset: rst is synchronous; afterwards a clearing pass over all 1024 entries zeroes the
//   per-element sums, during which in_stall stays high. Configuration is taken at once.
module l1_adagrad_dual_averaging_update import l1ada_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MEM_W = SQ_W + SUM_W;

  // The whole pipeline moves as one: it halts only while a finished result is held off.
  logic adv;
  logic accept;
  assign adv      = !(out_valid && out_stall);

  // Configuration registers. Writes are always accepted; unknown indices are ignored.
  logic [REG_W-1:0] lambda;
  logic [REG_W-1:0] gain;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda <= '0;
      gain   <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LAMBDA: lambda <= cfg_data[REG_W-1:0];
        REG_GAIN:   gain   <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // After reset the state memory is swept to zero, one entry per cycle.
  logic              clr_busy;
  logic [SLOT_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + SLOT_W'(1);
      if (clr_addr == SLOT_W'(ELEM_COUNT - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  assign in_stall = !adv || clr_busy;
  assign accept   = in_valid && !in_stall;

  // Stage 0: the accepted transaction, its squared gradient and the stored sums.
  // Each memory word holds the squared sum above the gradient sum.
  logic [MEM_W-1:0]  mem [0:ELEM_COUNT-1];
  logic [MEM_W-1:0]  rd_word;
  logic              s0_vld;
  in_item_t          s0_item;
  logic [SQ_W-1:0]   s0_sq;
  logic [GRAD_W-1:0] in_mag;

  assign in_mag = in_item.gradient_value[GRAD_W-1] ? GRAD_W'(-in_item.gradient_value)
                                                   : in_item.gradient_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item <= in_item;
      s0_sq   <= {32'b0, in_mag} * {32'b0, in_mag};
      rd_word <= mem[in_item.element_index[SLOT_W-1:0]];
    end
  end

  // Stage 1 registers; they also serve as the forwarding source for a back-to-back
  // transaction on the same element, whose memory read missed this write.
  logic                    s1_vld;
  logic [SLOT_W-1:0]       s1_slot;
  logic [IDX_W-1:0]        s1_idx;
  logic [CNT_W-1:0]        s1_cnt;
  logic [SQ_W-1:0]         s1_sq;
  logic signed [SUM_W-1:0] s1_u;
  logic                    s1_sat;

  logic [SLOT_W-1:0]       s0_slot;
  logic                    fwd;
  logic [SQ_W-1:0]         sq_old;
  logic signed [SUM_W-1:0] u_old;
  logic [SQ_W:0]           sq_sum;
  logic signed [SUM_W:0]   u_sum;
  logic [SQ_W-1:0]         sq_next;
  logic signed [SUM_W-1:0] u_next;
  logic                    sat_next;

  assign s0_slot = s0_item.element_index[SLOT_W-1:0];
  assign fwd     = s1_vld && (s1_slot == s0_slot);

  always_comb begin
    if (s0_item.first_pass) begin
      sq_old = '0;
      u_old  = '0;
    end else if (fwd) begin
      sq_old = s1_sq;
      u_old  = s1_u;
    end else begin
      sq_old = rd_word[MEM_W-1:SUM_W];
      u_old  = rd_word[SUM_W-1:0];
    end
    sat_next = 1'b0;
    sq_sum   = {1'b0, sq_old} + {1'b0, s0_sq};
    if (sq_sum[SQ_W]) begin
      sq_next  = '1;
      sat_next = 1'b1;
    end else begin
      sq_next = sq_sum[SQ_W-1:0];
    end
    u_sum = (SUM_W+1)'(u_old) + (SUM_W+1)'(s0_item.gradient_value);
    if (u_sum[SUM_W] != u_sum[SUM_W-1]) begin
      u_next   = u_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      sat_next = 1'b1;
    end else begin
      u_next = u_sum[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (adv && s0_vld) begin
      mem[s0_slot] <= {sq_next, u_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_slot <= s0_slot;
      s1_idx  <= s0_item.element_index;
      s1_cnt  <= s0_item.iteration_count;
      s1_sq   <= sq_next;
      s1_u    <= u_next;
      s1_sat  <= sat_next;
    end
  end

  // Stage 2: magnitude of the gradient sum and the threshold lambda times count.
  logic              s2_vld;
  coef_ctx_t         s2_ctx;
  logic [SQ_W-1:0]   s2_sq;
  logic [SUM_W-1:0]  s2_abs;
  logic [THR_W-1:0]  s2_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctx.idx <= s1_idx;
      s2_ctx.pos <= !s1_u[SUM_W-1] && (s1_u != '0);
      s2_ctx.nz  <= 1'b0;
      s2_ctx.sat <= s1_sat;
      s2_sq      <= s1_sq;
      s2_abs     <= s1_u[SUM_W-1] ? SUM_W'(-s1_u) : s1_u;
      s2_thr     <= {{CNT_W{1'b0}}, lambda} * {{REG_W{1'b0}}, s1_cnt};
    end
  end

  // Stage 3: the soft-threshold test and the excess over the threshold.
  logic              s3_vld;
  coef_ctx_t         s3_ctx;
  logic [SQ_W-1:0]   s3_sq;
  logic [SUM_W-1:0]  s3_diff;
  logic              over_thr;

  assign over_thr = THR_W'(s2_abs) > s2_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ctx.idx <= s2_ctx.idx;
      s3_ctx.pos <= s2_ctx.pos;
      s3_ctx.nz  <= over_thr;
      s3_ctx.sat <= s2_ctx.sat;
      s3_sq      <= s2_sq;
      s3_diff    <= over_thr ? SUM_W'(THR_W'(s2_abs) - s2_thr) : '0;
    end
  end

  // Stage 4: gain times the excess, as two partial products.
  logic                    s4_vld;
  coef_ctx_t               s4_ctx;
  logic [SQ_W-1:0]         s4_sq;
  logic [REG_W+HALF_W-1:0] s4_pp_hi;
  logic [REG_W+HALF_W-1:0] s4_pp_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ctx   <= s3_ctx;
      s4_sq    <= s3_sq;
      s4_pp_hi <= {{HALF_W{1'b0}}, gain} * {{REG_W{1'b0}}, s3_diff[SUM_W-1:HALF_W]};
      s4_pp_lo <= {{HALF_W{1'b0}}, gain} * {{REG_W{1'b0}}, s3_diff[HALF_W-1:0]};
    end
  end

  // Stage 5: the full dividend, handed to the square-root pipeline with the squared sum.
  logic            s5_vld;
  root_ctx_t       s5_ctx;
  logic [SQ_W-1:0] s5_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (adv) begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ctx.c   <= s4_ctx;
      s5_ctx.num <= {s4_pp_hi, {HALF_W{1'b0}}} + NUM_W'(s4_pp_lo);
      s5_sq      <= s4_sq;
    end
  end

  logic              rt_vld;
  logic [ROOT_W-1:0] rt_root;
  root_ctx_t         rt_ctx;
  logic [ROOT_W-1:0] rt_den;

  l1ada_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (s5_vld),
    .in_rad   (s5_sq),
    .in_ctx   (s5_ctx),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_ctx  (rt_ctx)
  );

  // A zero root only arises with a zero gradient sum; it is still kept off the divider.
  assign rt_den = (rt_root == '0) ? ROOT_W'(1) : rt_root;

  logic              dv_vld;
  logic [ROOT_W-1:0] dv_quo;
  logic              dv_ovf;
  coef_ctx_t         dv_ctx;

  l1ada_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (rt_vld),
    .in_num  (rt_ctx.num),
    .in_den  (rt_den),
    .in_ctx  (rt_ctx.c),
    .out_vld (dv_vld),
    .out_quo (dv_quo),
    .out_ovf (dv_ovf),
    .out_ctx (dv_ctx)
  );

  // Final stage: sign and saturation. A positive sum gives a negative coefficient,
  // which may reach minus two to the thirty-one; a negative sum is capped one below.
  logic [GRAD_W-1:0] coef_next;
  logic              clip;

  always_comb begin
    clip      = 1'b0;
    coef_next = '0;
    if (dv_ctx.nz) begin
      if (dv_ctx.pos) begin
        clip      = dv_ovf || (dv_quo > {1'b1, {(ROOT_W-1){1'b0}}});
        coef_next = clip ? {1'b1, {(GRAD_W-1){1'b0}}} : GRAD_W'(-dv_quo);
      end else begin
        clip      = dv_ovf || dv_quo[ROOT_W-1];
        coef_next = clip ? {1'b0, {(GRAD_W-1){1'b1}}} : GRAD_W'(dv_quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.result_index      <= dv_ctx.idx;
      out_item.coefficient_value <= coef_next;
      out_item.saturated         <= dv_ctx.sat || clip;
    end
  end

endmodule

// File: tb/tb_l1_adagrad_dual_averaging_update.sv
// Self-checking testbench for the L1 AdaGrad dual-averaging coefficient update block.
module tb_l1_adagrad_dual_averaging_update;
  import l1ada_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The settling pause allows for the pipeline depth of the block, held in
  // PIPE_LATENCY, and a margin on top.
  localparam int PIPE_LATENCY = 71;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 20;
  // Cycles without any transaction, while work is outstanding, before the run
  // is declared hung. The clearing pass after reset alone sweeps all 1024 entries.
  localparam int QUIET_LIMIT = 20000;
  localparam int BURST_LEN = 60;

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -64'sh0000_8000_0000_0000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(2);

  localparam logic signed [GRAD_W-1:0] GRAD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [GRAD_W-1:0] GRAD_MIN = 32'sh8000_0000;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Items waiting to be offered, and the coefficients the block ought to return.
  in_item_t  grad_feed_q[$];
  out_item_t coef_expect_q[$];

  // Predictor copy of the per-element sums and of the two registers.
  longint unsigned sq_grad_acc[ELEM_COUNT];
  longint          grad_acc[ELEM_COUNT];
  logic [REG_W-1:0] lambda_reg;
  logic [REG_W-1:0] gain_reg;

  // Percentage of cycles on which each side holds back; zero gives a stretch
  // with no idling at all. feed_hold stops the sender outright.
  int unsigned idle_pct;
  logic        feed_hold;
  logic        failed;

  int unsigned items_sent;
  int unsigned coefs_checked;
  int unsigned sat_seen;
  int unsigned nonzero_seen;
  int unsigned reg_writes;
  int unsigned quiet_cycles;

  l1_adagrad_dual_averaging_update i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Floor square root of a 64-bit value, worked out two bits at a time.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned acc;
    longint unsigned b;
    acc = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= acc + b) begin
        v = v - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return acc;
  endfunction

  // Updates the sums of one element and returns the coefficient that follows.
  function automatic out_item_t coef_update(in_item_t it);
    int unsigned     slot;
    longint          g;
    longint          u_old;
    longint          u_new;
    longint unsigned sq_old;
    longint unsigned sq_new;
    longint unsigned mag_g;
    longint unsigned abs_u;
    longint unsigned thr;
    longint unsigned diff;
    longint unsigned root;
    longint unsigned q;
    longint unsigned r;
    longint unsigned mag;
    logic            sat;
    logic            over;
    out_item_t       res;
    slot = it.element_index % ELEM_COUNT;
    g = it.gradient_value;
    sat = 1'b0;
    sq_old = it.first_pass ? 64'd0 : sq_grad_acc[slot];
    u_old = it.first_pass ? 64'sd0 : grad_acc[slot];

    mag_g = (g < 0) ? -g : g;
    sq_new = sq_old + mag_g * mag_g;
    if (sq_new < sq_old) begin
      sq_new = '1;
      sat = 1'b1;
    end
    u_new = u_old + g;
    if (u_new > SUM_HI) begin
      u_new = SUM_HI;
      sat = 1'b1;
    end else if (u_new < SUM_LO) begin
      u_new = SUM_LO;
      sat = 1'b1;
    end
    sq_grad_acc[slot] = sq_new;
    grad_acc[slot] = u_new;

    res.result_index = it.element_index;
    res.coefficient_value = '0;
    abs_u = (u_new < 0) ? -u_new : u_new;
    thr = 64'(lambda_reg) * 64'(it.iteration_count);
    if (abs_u > thr && gain_reg != 0) begin
      diff = abs_u - thr;
      root = floor_root(sq_new);
      if (root == 0) root = 1;
      q = diff / root;
      r = diff % root;
      over = (q > 64'h8000_0000);
      mag = over ? 64'd0 : 64'(gain_reg) * q + (64'(gain_reg) * r) / root;
      // A positive sum drives the coefficient negative, which reaches one step further.
      if (u_new > 0) begin
        if (over || mag > 64'h8000_0000) begin
          mag = 64'h8000_0000;
          sat = 1'b1;
        end
        res.coefficient_value = 32'(64'd0 - mag);
      end else begin
        if (over || mag > 64'h7FFF_FFFF) begin
          mag = 64'h7FFF_FFFF;
          sat = 1'b1;
        end
        res.coefficient_value = 32'(mag);
      end
    end
    res.saturated = sat;
    return res;
  endfunction

  function automatic in_item_t make_item(int unsigned idx, logic signed [GRAD_W-1:0] g,
                                         int unsigned cnt, bit first);
    in_item_t it;
    it.element_index = IDX_W'(idx);
    it.gradient_value = g;
    it.iteration_count = CNT_W'(cnt);
    it.first_pass = first;
    return it;
  endfunction

  // Random traffic keeps most transactions on a small set of hot elements so
  // that the sums build up over many items and same-element hazards arise
  // back to back; a few start afresh or touch the full index range.
  function automatic in_item_t random_item();
    int unsigned idx;
    int unsigned cnt;
    int unsigned pick;
    logic signed [GRAD_W-1:0] g;
    idx = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
    pick = $urandom_range(0, 99);
    if (pick < 40) g = $urandom;
    else if (pick < 90) g = $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
    else if (pick < 95) g = GRAD_MAX;
    else g = GRAD_MIN;
    pick = $urandom_range(0, 99);
    if (pick < 50) cnt = $urandom_range(1, 64);
    else if (pick < 98) cnt = $urandom_range(1, 20'hFFFFF);
    else cnt = 0;
    return make_item(idx, g, cnt, $urandom_range(0, 99) < 6);
  endfunction

  // Appends one item to the tail of the pending queue.
  task automatic queue_item(in_item_t it);
    grad_feed_q = {grad_feed_q, it};
  endtask

  // Sender: offers the next queued item whenever the current transaction has
  // gone through or nothing is on offer; a stalled payload is left alone.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        coef_expect_q = {coef_expect_q, coef_update(in_item)};
        items_sent <= items_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (grad_feed_q.size() > 0 && !feed_hold && $urandom_range(0, 99) >= idle_pct) begin
          in_item <= grad_feed_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random and checks every accepted result against the
  // oldest outstanding prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (coef_expect_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_item);
          failed <= 1'b1;
        end else begin
          want = coef_expect_q.pop_front();
          coefs_checked <= coefs_checked + 1;
          if (out_item.saturated) sat_seen <= sat_seen + 1;
          if (out_item.coefficient_value != 0) nonzero_seen <= nonzero_seen + 1;
          if (out_item.result_index !== want.result_index) begin
            $display("%0t: result_index expected %0d actual %0d", $time,
                     want.result_index, out_item.result_index);
            failed <= 1'b1;
          end
          if (out_item.coefficient_value !== want.coefficient_value) begin
            $display("%0t: coefficient_value (index %0d) expected %0d actual %0d", $time,
                     want.result_index, want.coefficient_value, out_item.coefficient_value);
            failed <= 1'b1;
          end
          if (out_item.saturated !== want.saturated) begin
            $display("%0t: saturated (index %0d) expected %0b actual %0b", $time,
                     want.result_index, want.saturated, out_item.saturated);
            failed <= 1'b1;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // Watchdog: only counts cycles in which work is outstanding and yet
  // nothing moves in either direction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (grad_feed_q.size() == 0 && coef_expect_q.size() == 0 && !in_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Waits for every queued item to be taken and every result to return, then
  // lets the pipeline drain fully before anything else changes.
  task automatic settle();
    while (grad_feed_q.size() > 0 || in_valid || coef_expect_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the channel is left idle afterwards so that
  // consecutive writes never drive the same signal twice in one step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // Only the low 31 bits are held; an unknown index changes nothing.
    if (idx == REG_LAMBDA) lambda_reg = data[REG_W-1:0];
    else if (idx == REG_GAIN) gain_reg = data[REG_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic random_phase(int unsigned n);
    repeat (n) queue_item(random_item());
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_LAMBDA;
    cfg_data <= '0;
    feed_hold = 1'b0;
    failed = 1'b0;
    idle_pct = 10;
    items_sent = 0;
    coefs_checked = 0;
    sat_seen = 0;
    nonzero_seen = 0;
    reg_writes = 0;
    quiet_cycles = 0;
    lambda_reg = '0;
    gain_reg = GAIN_RESET;
    for (int k = 0; k < ELEM_COUNT; k++) begin
      sq_grad_acc[k] = 0;
      grad_acc[k] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: field extremes, a zero count,
    // a zero gradient with a zero root, a sum that cancels back to zero, and
    // a squared sum driven past its ceiling.
    queue_item(make_item(0, GRAD_MAX, 1, 1));
    queue_item(make_item(0, GRAD_MAX, CNT_MAX, 0));
    queue_item(make_item(1023, GRAD_MIN, 1, 1));
    queue_item(make_item(1023, GRAD_MIN, 0, 0));
    queue_item(make_item(2, 0, 5, 1));
    queue_item(make_item(3, 1, 1, 1));
    queue_item(make_item(3, -1, 2, 0));
    queue_item(make_item(4, GRAD_MIN, 1, 1));
    repeat (4) queue_item(make_item(4, GRAD_MIN, 2, 0));
    queue_item(make_item(512, 32'sh0001_0000, 3, 1));
    queue_item(make_item(0, -32'sh0000_4000, 777, 0));
    settle();

    // Extreme register values; bit 31 of the data must be dropped and the
    // unused register index must be ignored.
    write_reg(REG_LAMBDA, 32'hFFFF_FFFF);
    write_reg(REG_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, 32'h0000_1234);
    queue_item(make_item(5, GRAD_MAX, 0, 1));
    queue_item(make_item(5, GRAD_MAX, 1, 0));
    queue_item(make_item(6, GRAD_MIN, 0, 1));
    queue_item(make_item(6, GRAD_MIN, 0, 0));
    settle();
    write_reg(REG_LAMBDA, 32'd0);
    queue_item(make_item(5, GRAD_MAX, 1, 0));
    queue_item(make_item(6, GRAD_MIN, 1, 0));
    queue_item(make_item(8, 32'sh0000_0100, 1, 1));
    queue_item(make_item(8, 32'sh0000_0100, 1, 0));
    settle();

    // Random traffic at maximum gain and no threshold, so that the
    // coefficient saturates often; the sender pauses partway until every
    // outstanding result has returned.
    random_phase(400);
    while (grad_feed_q.size() > 200) @(posedge clk);
    feed_hold = 1'b1;
    while (in_valid || coef_expect_q.size() > 0) @(posedge clk);
    feed_hold = 1'b0;
    settle();

    // Zero gain forces every coefficient to zero.
    write_reg(REG_GAIN, 32'd0);
    random_phase(200);
    settle();

    // Moderate settings with random content, first with no idling at all.
    write_reg(REG_LAMBDA, 32'($urandom_range(0, 32'h0000_4000)));
    write_reg(REG_GAIN, 32'($urandom_range(1, 32'h0004_0000)));
    idle_pct = 0;
    random_phase(400);
    settle();
    idle_pct = 10;
    write_reg(REG_LAMBDA, 32'($urandom_range(0, 32'h0100_0000)));
    write_reg(REG_GAIN, 32'($urandom));
    random_phase(400);
    settle();
    write_reg(REG_LAMBDA, 32'($urandom_range(0, 32'h40)));
    write_reg(REG_GAIN, 32'h0001_0000);
    random_phase(300);
    settle();

    // Back-to-back runs of the largest gradient of each sign on one element,
    // with no idling, so that every transaction after the first of each run takes the forwarding path.
    idle_pct = 0;
    queue_item(make_item(9, GRAD_MAX, 1, 1));
    repeat (BURST_LEN) queue_item(make_item(9, GRAD_MAX, 1, 0));
    queue_item(make_item(10, GRAD_MIN, 1, 1));
    repeat (BURST_LEN) queue_item(make_item(10, GRAD_MIN, 1, 0));
    settle();

    $display("tb: %0d gradient items sent, %0d coefficients checked, %0d register writes",
             items_sent, coefs_checked, reg_writes);
    $display("tb: %0d saturated and %0d nonzero coefficients seen", sat_seen, nonzero_seen);
    if (!failed && coef_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      if (coef_expect_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, coef_expect_q.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
